// ===== hw/rtl/cfl_time_step_minimum_assert.svh =====
// Assertion macros for the CFL time-step block.
`ifndef CFL_TIME_STEP_MINIMUM_ASSERT_SVH
`define CFL_TIME_STEP_MINIMUM_ASSERT_SVH
`define CFL_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define CFL_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/cfl_pkg.sv =====
// Shared types and constants for the CFL time-step block.
package cfl_pkg;
  localparam int OUT_FRAC = 28;
  localparam logic [47:0] MIN_RESET = 48'd268435456000000;
  localparam logic [47:0] OUT_MAX = '1;
  localparam logic [31:0] GRAVITY_RESET = 32'd642908;
  localparam logic [1:0] REGION_WET = 2'd0;
  localparam logic [1:0] REGION_DRY = 2'd1;
  localparam logic [1:0] REGION_OTHER = 2'd2;
  localparam logic [1:0] REGION_SPARE = 2'd3;
  localparam logic CFG_GRAVITY = 1'b0;
  localparam logic CFG_ORDER = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_MAG, ST_SQRT_MAG, ST_DIV_SPEED, ST_SQ_CEL, ST_SQRT_CEL,
    ST_MUL_DEN, ST_DIV_LOCAL, ST_UPDATE, ST_OUT
  } cfl_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } cfl_unit_ctl_t;
endpackage

// ===== hw/rtl/cfl_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module cfl_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          radicand,
  output cfl_pkg::cfl_unit_ctl_t ctl,
  output logic [31:0]          root
);
  import cfl_pkg::*;
  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [35:0] shifted;
  logic [36:0] trial;

  always_comb begin
    rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    shifted = {rem_r, rad_r[63:62]};
    trial = {1'b0, shifted} - {3'b000, root_r, 2'b01};
    if (start) begin
      rad_nxt = radicand; rem_nxt = '0; root_nxt = '0;
      cnt_nxt = 6'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (!trial[36]) begin
        rem_nxt = trial[33:0]; root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[33:0]; root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt; rem_r <= rem_nxt; root_r <= root_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign ctl.start = busy_r;
  assign ctl.done = done_r;
  assign root = root_r;
endmodule

// ===== hw/rtl/cfl_div.sv =====
// Bit-serial restoring divider: 64-bit dividend, DVS_W-bit divisor, one bit per cycle.
module cfl_div #(
  parameter int DVS_W = 54
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [DVS_W-1:0]     divisor,
  output cfl_pkg::cfl_unit_ctl_t ctl,
  output logic [63:0]          quotient
);
  import cfl_pkg::*;
  logic [63:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [DVS_W+1:0] trial;
  logic [DVS_W:0] shifted;

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    shifted = {rem_r, quo_r[63]};
    trial = {1'b0, shifted} - {2'b00, dvs_r};
    if (start) begin
      quo_nxt = dividend; rem_nxt = '0; dvs_nxt = divisor;
      cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DVS_W+1]) begin
        rem_nxt = trial[DVS_W-1:0]; quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0]; quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign ctl.start = busy_r;
  assign ctl.done = done_r;
  assign quotient = quo_r;
endmodule

// ===== hw/rtl/cfl_time_step_minimum.sv =====
// CFL time-step minimum, top level with a sequencer over shared serial units.
// Wet node, nonzero depth: two square roots and two divides; other cells one square root
// and one divide; a zero denominator skips the divide; a dry node goes straight to output.
// One item at a time; the serial units set the rate. A result waits in the output
// register while the next item is accepted; a last node waits for that register.
// Synchronous active-low reset: minimum to 1e6, gravity 642908, order 1, no result.
module cfl_time_step_minimum #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_region_type,
  input  logic [31:0] in_cell_size,
  input  logic [31:0] in_depth,
  input  logic signed [31:0] in_discharge_x,
  input  logic signed [31:0] in_discharge_y,
  input  logic        in_last_node,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_time_step
);
  import cfl_pkg::*;
  `include "cfl_time_step_minimum_assert.svh"

  // speed plus celerity, then times 2N+1
  localparam int SPEED_W = FRACTION_BITS + 33;
  localparam int DEN_W = SPEED_W + 5;

  cfl_state_t state_r, state_nxt;
  logic [31:0] grav_r;
  logic [3:0] ord_r;
  logic [47:0] min_r, min_nxt;
  logic [47:0] res_r, res_nxt;
  logic res_v_r, res_v_nxt;
  logic [31:0] dx_r, h_r, ax_r, ay_r;
  logic last_r;
  logic [63:0] acc_r, acc_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [63:0] local_r, local_nxt;

  logic sq_start, dv_start;
  logic [63:0] sq_in, dv_a;
  logic [DEN_W-1:0] dv_b;
  cfl_unit_ctl_t sq_ctl, dv_ctl;
  logic [31:0] sq_root;
  logic [63:0] dv_q;
  logic [4:0] odd;
  logic [DEN_W-1:0] den;
  logic accept;

  cfl_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand(sq_in),
                   .ctl(sq_ctl), .root(sq_root));
  cfl_div #(.DVS_W(DEN_W)) u_div (.clk, .rst_n, .start(dv_start), .dividend(dv_a),
                                  .divisor(dv_b), .ctl(dv_ctl), .quotient(dv_q));

  assign in_stall = (state_r != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = res_v_r;
  assign out_time_step = res_r;
  assign odd = {ord_r, 1'b1};
  assign den = DEN_W'(speed_r) * DEN_W'(odd);

  always_comb begin
    state_nxt = state_r; min_nxt = min_r; res_nxt = res_r;
    res_v_nxt = res_v_r && out_stall; acc_nxt = acc_r;
    speed_nxt = speed_r; local_nxt = local_r;
    sq_start = 1'b0; dv_start = 1'b0;
    sq_in = acc_r; dv_a = '0; dv_b = '0;
    case (state_r)
      ST_IDLE: if (accept) begin
        speed_nxt = '0;
        if (in_region_type == REGION_DRY) state_nxt = ST_OUT;
        else if (in_region_type == REGION_WET && in_depth != '0) state_nxt = ST_SQ_MAG;
        else state_nxt = ST_SQ_CEL;
      end
      ST_SQ_MAG: begin
        acc_nxt = 64'(ax_r) * 64'(ax_r) + 64'(ay_r) * 64'(ay_r);
        state_nxt = ST_SQRT_MAG;
      end
      ST_SQRT_MAG: begin
        sq_start = !sq_ctl.start && !sq_ctl.done;
        if (sq_ctl.done) begin
          dv_start = 1'b1;
          dv_a = 64'(sq_root) << FRACTION_BITS;
          dv_b = DEN_W'(h_r);
          state_nxt = ST_DIV_SPEED;
        end
      end
      ST_DIV_SPEED: if (dv_ctl.done) begin
        speed_nxt = SPEED_W'(dv_q);
        state_nxt = ST_SQ_CEL;
      end
      ST_SQ_CEL: begin
        acc_nxt = 64'(grav_r) * 64'(h_r);
        state_nxt = ST_SQRT_CEL;
      end
      ST_SQRT_CEL: begin
        sq_start = !sq_ctl.start && !sq_ctl.done;
        if (sq_ctl.done) begin
          speed_nxt = speed_r + SPEED_W'(sq_root);
          state_nxt = ST_MUL_DEN;
        end
      end
      ST_MUL_DEN: begin
        if (den == '0) begin
          local_nxt = 64'(OUT_MAX);
          state_nxt = ST_UPDATE;
        end else begin
          dv_start = 1'b1;
          dv_a = 64'(dx_r) << OUT_FRAC;
          dv_b = den;
          state_nxt = ST_DIV_LOCAL;
        end
      end
      ST_DIV_LOCAL: if (dv_ctl.done) begin
        local_nxt = (dv_q[63:48] != '0) ? 64'(OUT_MAX) : dv_q;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (local_r[47:0] < min_r) min_nxt = local_r[47:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!last_r) state_nxt = ST_IDLE;
        else if (!res_v_r || !out_stall) begin
          res_nxt = min_r; res_v_nxt = 1'b1; min_nxt = MIN_RESET;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; speed_r <= speed_nxt; local_r <= local_nxt; res_r <= res_nxt;
    if (accept) begin
      dx_r <= in_cell_size; h_r <= in_depth;
      ax_r <= in_discharge_x[31] ? 32'(-in_discharge_x) : in_discharge_x;
      ay_r <= in_discharge_y[31] ? 32'(-in_discharge_y) : in_discharge_y;
      last_r <= in_last_node;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE; min_r <= MIN_RESET; res_v_r <= 1'b0;
      grav_r <= GRAVITY_RESET; ord_r <= 4'd1;
    end else begin
      state_r <= state_nxt; min_r <= min_nxt; res_v_r <= res_v_nxt;
      if (cfg_we && cfg_index == CFG_GRAVITY) grav_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_ORDER) ord_r <= cfg_data[3:0];
    end
  end

  `CFL_ASSERT_IMPL(a_busy_stall, state_r != ST_IDLE, in_stall)
  `CFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_time_step))
  `CFL_ASSERT_IMPL(a_min_range, 1'b1, min_r <= MIN_RESET)
endmodule

// ===== tb/cfl_checker.sv =====
// Checker for the CFL time-step block: watches the ports, predicts the minimum, compares.
module cfl_checker #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_region_type,
  input  logic [31:0]        in_cell_size,
  input  logic [31:0]        in_depth,
  input  logic signed [31:0] in_discharge_x,
  input  logic signed [31:0] in_discharge_y,
  input  logic               in_last_node,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [47:0]        out_time_step,
  output int                 fail_count,
  output int                 pending
);
  import cfl_pkg::*;

  logic [31:0] gravity_q;
  logic [3:0]  order_q;
  logic [47:0] sweep_min;
  logic [47:0] step_queue[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs32(input logic [31:0] v);
    logic [31:0] t;
    t = v[31] ? (~v + 32'd1) : v;
    return {32'd0, t};
  endfunction

  // local stable step of one node, Q20.28, saturated
  function automatic logic [47:0] node_step(input logic [1:0] region, input logic [31:0] dx,
                                            input logic [31:0] h, input logic [31:0] hu,
                                            input logic [31:0] hv);
    logic [63:0] speed;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] denom;
    logic [63:0] q;
    speed = '0;
    if (region == REGION_WET && h != 0) begin
      ax = abs32(hu);
      ay = abs32(hv);
      speed = (int_sqrt(ax * ax + ay * ay) << FRACTION_BITS) / {32'd0, h};
    end
    denom = (speed + int_sqrt({32'd0, gravity_q} * {32'd0, h}))
            * (64'd2 * {60'd0, order_q} + 64'd1);
    if (denom == 0) return OUT_MAX;
    q = ({32'd0, dx} << OUT_FRAC) / denom;
    if (q > {16'd0, OUT_MAX}) return OUT_MAX;
    return q[47:0];
  endfunction

  assign pending = step_queue.size();

  always @(posedge clk) begin
    logic [47:0] s;
    logic [47:0] m;
    if (!rst_n) begin
      gravity_q <= GRAVITY_RESET;
      order_q <= 4'd1;
      sweep_min <= MIN_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRAVITY) gravity_q <= cfg_data;
        else order_q <= cfg_data[3:0];
      end
      if (in_valid && !in_stall) begin
        m = sweep_min;
        if (in_region_type != REGION_DRY) begin
          s = node_step(in_region_type, in_cell_size, in_depth, in_discharge_x,
                        in_discharge_y);
          if (s < m) m = s;
        end
        if (in_last_node) begin
          step_queue.push_back(m);
          sweep_min <= MIN_RESET;
        end else begin
          sweep_min <= m;
        end
      end
      if (out_valid && !out_stall) begin
        if (step_queue.size() == 0) begin
          $error("unexpected result: time_step %0d", out_time_step);
          fail_count <= fail_count + 1;
        end else begin
          s = step_queue.pop_front();
          if (out_time_step !== s) begin
            $error("time_step mismatch: expected %0d, actual %0d", s, out_time_step);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the CFL time-step block: clock, reset, stimulus and verdict.
module tb_top;
  import cfl_pkg::*;

  localparam int CYCLE_LIMIT = 2500000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_GRAVITY;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_region_type = '0;
  logic [31:0]        in_cell_size = '0;
  logic [31:0]        in_depth = '0;
  logic signed [31:0] in_discharge_x = '0;
  logic signed [31:0] in_discharge_y = '0;
  logic               in_last_node = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [47:0]        out_time_step;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  int                 results_taken = 0;
  bit                 send_busy_gaps = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cfl_time_step_minimum dut (.*);

  cfl_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: random stall per result, quiet stretches, and one long hold-off
  initial begin
    int w;
    forever begin
      w = ((results_taken / 40) % 3 == 0) ? 0 : $urandom_range(0, 19);
      if (results_taken == 20) w = 1500;
      if (w > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  task automatic send_node(input logic [1:0] region, input logic [31:0] dx,
                           input logic [31:0] h, input logic [31:0] hu,
                           input logic [31:0] hv, input logic last);
    int gap;
    gap = send_busy_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_region_type <= region;
    in_cell_size <= dx;
    in_depth <= h;
    in_discharge_x <= hu;
    in_discharge_y <= hv;
    in_last_node <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_depth();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1, 2: return $urandom_range(1, 32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_flow();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  task automatic random_sweeps(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 8);
      send_busy_gaps = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < len; k++) begin
        send_node(2'($urandom_range(0, 3)),
                  ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 32'h0004_0000),
                  pick_depth(), pick_flow(), pick_flow(), k == len - 1);
        n++;
      end
    end
    send_busy_gaps = 1'b1;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: wet nodes at the field extremes
    send_node(REGION_WET, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 1'b1);
    send_node(REGION_WET, '1, '1, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_node(REGION_WET, '1, 32'd1, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    // wet node with zero depth: speed is zero
    send_node(REGION_WET, 32'h0003_0000, 32'd0, 32'h1234_5678, 32'hfedc_ba98, 1'b1);
    // region type 3 behaves like other cells
    send_node(REGION_SPARE, 32'h0005_0000, 32'h0000_4000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_node(REGION_OTHER, 32'h0005_0000, 32'h0000_4000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    // dry last node still emits; an all-dry sweep emits 1e6
    send_node(REGION_WET, 32'h0000_0100, 32'h0010_0000, 32'd0, 32'd0, 1'b0);
    send_node(REGION_DRY, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1);
    send_node(REGION_DRY, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    send_node(REGION_DRY, '1, '1, '1, '1, 1'b1);
    // huge step saturates
    send_node(REGION_OTHER, '1, 32'd1, 32'd0, 32'd0, 1'b1);
    drain();

    // zero gravity: zero denominator saturates
    write_reg(CFG_GRAVITY, 32'd0);
    write_reg(CFG_ORDER, 32'd0);
    send_node(REGION_OTHER, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0, 1'b1);
    send_node(REGION_WET, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'd0, 1'b1);
    send_node(REGION_WET, 32'd0, 32'h0002_0000, 32'd0, 32'd0, 1'b1);
    random_sweeps(290);
    drain();

    write_reg(CFG_GRAVITY, '1);
    write_reg(CFG_ORDER, 32'd15);
    send_node(REGION_WET, '1, '1, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    random_sweeps(290);
    drain();

    write_reg(CFG_GRAVITY, GRAVITY_RESET);
    write_reg(CFG_ORDER, 32'd1);
    random_sweeps(290);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_GRAVITY, $urandom);
      write_reg(CFG_ORDER, $urandom_range(0, 15));
      random_sweeps(290);
      drain();
    end

    @(negedge clk) in_valid <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
